// ===== src/si_pkg.sv =====
// shared widths, defaults and payload structs of the segment intersection pipeline
package si_pkg;

  localparam int COORD_W       = 16;
  localparam int DIFF_W        = COORD_W + 1;
  localparam int PROD_W        = 2 * DIFF_W;
  localparam int CROSS_W       = PROD_W + 1;
  localparam int NUM_W         = CROSS_W + DIFF_W;
  localparam int OUT_W         = 24;
  localparam int IN_DATA_W     = 8 * COORD_W;
  localparam int OUT_DATA_W    = 2 * OUT_W;
  localparam int FRAC_BITS_DEF = 8;

  // front end to divider: hit flag, base point, |den| and signed numerators
  typedef struct packed {
    logic                      hit;
    logic signed [COORD_W-1:0] base_x;
    logic signed [COORD_W-1:0] base_y;
    logic [CROSS_W-1:0]        den;
    logic signed [NUM_W-1:0]   num_x;
    logic signed [NUM_W-1:0]   num_y;
  } frt_t;

  // sideband that rides along the divider stages
  typedef struct packed {
    logic                      hit;
    logic signed [COORD_W-1:0] base_x;
    logic signed [COORD_W-1:0] base_y;
    logic [CROSS_W-1:0]        den;
  } sb_t;

endpackage

// ===== src/si_front.sv =====
// front end: differences, cross products, unit range test and numerator products
module si_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [si_pkg::IN_DATA_W-1:0]   in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output si_pkg::frt_t                   out_pl
);

  localparam int NS = 5;
  localparam int CW = si_pkg::COORD_W;
  localparam int DW = si_pkg::DIFF_W;
  localparam int PW = si_pkg::PROD_W;
  localparam int XW = si_pkg::CROSS_W;
  localparam int NW = si_pkg::NUM_W;

  logic [NS-1:0] v_r;
  logic [NS:0]   rdy;

  // stage 1: differences
  logic signed [DW-1:0] d1x_r, d1y_r, d2x_r, d2y_r, wx_r, wy_r;
  logic signed [CW-1:0] b1x_r, b1y_r;
  // stage 2: products
  logic signed [PW-1:0] pda_r, pdb_r, psa_r, psb_r, pta_r, ptb_r;
  logic signed [DW-1:0] d1x2_r, d1y2_r;
  logic signed [CW-1:0] b2x_r, b2y_r;
  // stage 3: cross sums
  logic signed [XW-1:0] den_r, sn_r, tn_r;
  logic signed [DW-1:0] d1x3_r, d1y3_r;
  logic signed [CW-1:0] b3x_r, b3y_r;
  // stage 4: hit test and sign fix
  logic                 hit4_r;
  logic [XW-1:0]        dabs4_r;
  logic signed [XW-1:0] tadj4_r;
  logic signed [DW-1:0] d1x4_r, d1y4_r;
  logic signed [CW-1:0] b4x_r, b4y_r;
  // stage 5: numerator products
  logic                 hit5_r;
  logic [XW-1:0]        dabs5_r;
  logic signed [NW-1:0] nx5_r, ny5_r;
  logic signed [CW-1:0] b5x_r, b5y_r;

  logic signed [CW-1:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
  logic                 hit_nxt;
  logic [XW-1:0]        dabs_nxt;
  logic signed [XW-1:0] tadj_nxt;

  // 0 <= num/den <= 1
  function automatic logic unit_range(input logic signed [XW-1:0] num,
                                      input logic signed [XW-1:0] den);
    logic res;
    if (den > 0) begin
      res = (num >= 0) && (num <= den);
    end else if (den < 0) begin
      res = (num <= 0) && (num >= den);
    end else begin
      res = 1'b0;
    end
    return res;
  endfunction

  // field split
  assign ax0 = in_data[15:0];
  assign ay0 = in_data[31:16];
  assign ax1 = in_data[47:32];
  assign ay1 = in_data[63:48];
  assign bx0 = in_data[79:64];
  assign by0 = in_data[95:80];
  assign bx1 = in_data[111:96];
  assign by1 = in_data[127:112];

  // per-stage ready chain, a stage moves when empty or its successor moves
  assign rdy[NS] = out_ready;
  for (genvar k = 0; k < NS; k++) begin : g_rdy
    assign rdy[k] = !v_r[k] || rdy[k+1];
  end
  assign in_ready  = rdy[0];
  assign out_valid = v_r[NS-1];

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (rdy[k]) begin
          v_r[k] <= (k == 0) ? in_valid : v_r[k-1];
        end
      end
    end
  end

  // stage 1
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      d1x_r <= DW'(ax1) - DW'(ax0);
      d1y_r <= DW'(ay1) - DW'(ay0);
      d2x_r <= DW'(bx1) - DW'(bx0);
      d2y_r <= DW'(by1) - DW'(by0);
      wx_r  <= DW'(ax0) - DW'(bx0);
      wy_r  <= DW'(ay0) - DW'(by0);
      b1x_r <= ax0;
      b1y_r <= ay0;
    end
  end

  // stage 2
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      pda_r  <= d1x_r * d2y_r;
      pdb_r  <= d2x_r * d1y_r;
      psa_r  <= d1x_r * wy_r;
      psb_r  <= d1y_r * wx_r;
      pta_r  <= d2x_r * wy_r;
      ptb_r  <= d2y_r * wx_r;
      d1x2_r <= d1x_r;
      d1y2_r <= d1y_r;
      b2x_r  <= b1x_r;
      b2y_r  <= b1y_r;
    end
  end

  // stage 3
  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      den_r  <= XW'(pda_r) - XW'(pdb_r);
      sn_r   <= XW'(psa_r) - XW'(psb_r);
      tn_r   <= XW'(pta_r) - XW'(ptb_r);
      d1x3_r <= d1x2_r;
      d1y3_r <= d1y2_r;
      b3x_r  <= b2x_r;
      b3y_r  <= b2y_r;
    end
  end

  // hit test, denominator made positive
  always_comb begin
    hit_nxt  = unit_range(sn_r, den_r) && unit_range(tn_r, den_r);
    dabs_nxt = (den_r < 0) ? XW'(-den_r) : XW'(den_r);
    tadj_nxt = (den_r < 0) ? -tn_r : tn_r;
  end

  // stage 4
  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      hit4_r  <= hit_nxt;
      dabs4_r <= dabs_nxt;
      tadj4_r <= tadj_nxt;
      d1x4_r  <= d1x3_r;
      d1y4_r  <= d1y3_r;
      b4x_r   <= b3x_r;
      b4y_r   <= b3y_r;
    end
  end

  // stage 5
  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      hit5_r  <= hit4_r;
      dabs5_r <= dabs4_r;
      nx5_r   <= tadj4_r * d1x4_r;
      ny5_r   <= tadj4_r * d1y4_r;
      b5x_r   <= b4x_r;
      b5y_r   <= b4y_r;
    end
  end

  assign out_pl.hit    = hit5_r;
  assign out_pl.base_x = b5x_r;
  assign out_pl.base_y = b5y_r;
  assign out_pl.den    = dabs5_r;
  assign out_pl.num_x  = nx5_r;
  assign out_pl.num_y  = ny5_r;

  // a hit always carries a nonzero denominator and a nonnegative ratio numerator
  a_hit_den: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[3] && hit4_r |-> (dabs4_r != '0) && (tadj4_r >= 0))
    else $error("hit with zero denominator or negative numerator");

endmodule

// ===== src/si_div.sv =====
// pipelined restoring divider, one quotient bit per stage, x and y lanes share the divisor
module si_div #(
  parameter int FRAC_BITS = si_pkg::FRAC_BITS_DEF
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         in_valid,
  output logic                                         in_ready,
  input  si_pkg::frt_t                                 in_pl,
  output logic                                         out_valid,
  input  logic                                         out_ready,
  output si_pkg::sb_t                                  out_sb,
  output logic [si_pkg::DIFF_W-2+FRAC_BITS:0]          out_q_x,
  output logic [si_pkg::DIFF_W-2+FRAC_BITS:0]          out_q_y,
  output logic [si_pkg::CROSS_W-1:0]                   out_rem_x,
  output logic [si_pkg::CROSS_W-1:0]                   out_rem_y,
  output logic                                         out_neg_x,
  output logic                                         out_neg_y
);

  // quotient stays below 2^QW since |t| <= 1 and |d1| < 2^16
  localparam int QW  = si_pkg::DIFF_W - 1 + FRAC_BITS;
  localparam int MW  = si_pkg::NUM_W - 1;
  localparam int DVW = MW + FRAC_BITS;
  localparam int RW  = si_pkg::CROSS_W;
  localparam int NS  = QW + 1;

  logic [NS-1:0]  v_r;
  logic [NS:0]    rdy;
  si_pkg::sb_t    sb_r   [NS];
  logic [RW-1:0]  rem_r  [NS][2];
  logic [QW-1:0]  low_r  [NS][2];
  logic [QW-1:0]  q_r    [NS][2];
  logic           neg_r  [NS][2];

  logic [RW-1:0]  rem_nxt [NS][2];
  logic [QW-1:0]  low_nxt [NS][2];
  logic [QW-1:0]  q_nxt   [NS][2];
  logic           neg_nxt [2];

  logic signed [si_pkg::NUM_W-1:0] num_l [2];
  logic [MW-1:0]  mag;
  logic [DVW-1:0] dvd;
  logic [RW:0]    trial;
  logic           ge;

  assign num_l[0] = in_pl.num_x;
  assign num_l[1] = in_pl.num_y;

  // ready chain
  assign rdy[NS] = out_ready;
  for (genvar k = 0; k < NS; k++) begin : g_rdy
    assign rdy[k] = !v_r[k] || rdy[k+1];
  end
  assign in_ready  = rdy[0];
  assign out_valid = v_r[NS-1];

  // next values: stage 0 splits |num| << F, later stages do one trial subtract each
  always_comb begin
    mag   = '0;
    dvd   = '0;
    trial = '0;
    ge    = 1'b0;
    for (int l = 0; l < 2; l++) begin
      mag           = (num_l[l] < 0) ? MW'(-num_l[l]) : MW'(num_l[l]);
      dvd           = DVW'(mag) << FRAC_BITS;
      neg_nxt[l]    = num_l[l] < 0;
      rem_nxt[0][l] = RW'(dvd >> QW);
      low_nxt[0][l] = dvd[QW-1:0];
      q_nxt[0][l]   = '0;
    end
    for (int k = 1; k < NS; k++) begin
      for (int l = 0; l < 2; l++) begin
        trial         = {rem_r[k-1][l], low_r[k-1][l][QW-1]};
        ge            = trial >= {1'b0, sb_r[k-1].den};
        rem_nxt[k][l] = ge ? RW'(trial - {1'b0, sb_r[k-1].den}) : RW'(trial);
        low_nxt[k][l] = low_r[k-1][l] << 1;
        q_nxt[k][l]   = {q_r[k-1][l][QW-2:0], ge};
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (rdy[k]) begin
          v_r[k] <= (k == 0) ? in_valid : v_r[k-1];
        end
      end
    end
  end

  // stage registers
  always_ff @(posedge clk) begin
    for (int k = 0; k < NS; k++) begin
      if (rdy[k]) begin
        if (k == 0) begin
          sb_r[k].hit    <= in_pl.hit;
          sb_r[k].base_x <= in_pl.base_x;
          sb_r[k].base_y <= in_pl.base_y;
          sb_r[k].den    <= in_pl.den;
        end else begin
          sb_r[k] <= sb_r[k-1];
        end
        for (int l = 0; l < 2; l++) begin
          rem_r[k][l] <= rem_nxt[k][l];
          low_r[k][l] <= low_nxt[k][l];
          q_r[k][l]   <= q_nxt[k][l];
          neg_r[k][l] <= (k == 0) ? neg_nxt[l] : neg_r[k-1][l];
        end
      end
    end
  end

  assign out_sb    = sb_r[NS-1];
  assign out_q_x   = q_r[NS-1][0];
  assign out_q_y   = q_r[NS-1][1];
  assign out_rem_x = rem_r[NS-1][0];
  assign out_rem_y = rem_r[NS-1][1];
  assign out_neg_x = neg_r[NS-1][0];
  assign out_neg_y = neg_r[NS-1][1];

  // on a hit the final remainders are proper, below the divisor
  a_rem_lt_den: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[NS-1] && sb_r[NS-1].hit |->
      (rem_r[NS-1][0] < sb_r[NS-1].den) && (rem_r[NS-1][1] < sb_r[NS-1].den))
    else $error("divider remainder not below divisor");

endmodule

// ===== src/si_round.sv =====
// signed floor from quotient and remainder, round half away from zero, output register
module si_round #(
  parameter int FRAC_BITS = si_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  si_pkg::sb_t                          in_sb,
  input  logic [si_pkg::DIFF_W-2+FRAC_BITS:0]  in_q_x,
  input  logic [si_pkg::DIFF_W-2+FRAC_BITS:0]  in_q_y,
  input  logic [si_pkg::CROSS_W-1:0]           in_rem_x,
  input  logic [si_pkg::CROSS_W-1:0]           in_rem_y,
  input  logic                                 in_neg_x,
  input  logic                                 in_neg_y,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_hit,
  output logic [si_pkg::OUT_W-1:0]             out_cross_x,
  output logic [si_pkg::OUT_W-1:0]             out_cross_y
);

  localparam int QW = si_pkg::DIFF_W - 1 + FRAC_BITS;
  localparam int RW = si_pkg::CROSS_W;
  localparam int FW = QW + 2;
  localparam int TW = QW + 3;
  localparam int OW = si_pkg::OUT_W;

  logic [1:0] v_r;
  logic [2:0] rdy;

  // stage 1 registers
  logic                          hit1_r;
  logic signed [si_pkg::COORD_W-1:0] base1_r [2];
  logic signed [FW-1:0]          fl1_r   [2];
  logic                          sure1_r [2];
  logic                          tie1_r  [2];
  // output registers
  logic                          hit_r;
  logic [OW-1:0]                 cross_r [2];

  logic [QW-1:0]        q_l    [2];
  logic [RW-1:0]        r_l    [2];
  logic                 neg_l  [2];
  logic signed [FW-1:0] fl_nxt   [2];
  logic                 sure_nxt [2];
  logic                 tie_nxt  [2];
  logic signed [TW-1:0] total    [2];
  logic signed [TW-1:0] res      [2];
  logic [OW-1:0]        cross_nxt [2];
  logic                 nz, lt, eq, gt, up;

  assign q_l[0]   = in_q_x;
  assign q_l[1]   = in_q_y;
  assign r_l[0]   = in_rem_x;
  assign r_l[1]   = in_rem_y;
  assign neg_l[0] = in_neg_x;
  assign neg_l[1] = in_neg_y;

  // ready chain
  assign rdy[2] = out_ready;
  for (genvar k = 0; k < 2; k++) begin : g_rdy
    assign rdy[k] = !v_r[k] || rdy[k+1];
  end
  assign in_ready  = rdy[0];
  assign out_valid = v_r[1];

  // signed floor and rounding flags; for negative numerators the remainder is den - r
  always_comb begin
    nz = 1'b0;
    lt = 1'b0;
    eq = 1'b0;
    gt = 1'b0;
    for (int l = 0; l < 2; l++) begin
      nz = r_l[l] != '0;
      lt = {r_l[l], 1'b0} <  {1'b0, in_sb.den};
      eq = {r_l[l], 1'b0} == {1'b0, in_sb.den};
      gt = {r_l[l], 1'b0} >  {1'b0, in_sb.den};
      fl_nxt[l]   = neg_l[l] ? -$signed({2'b00, q_l[l]}) - FW'(nz)
                             : $signed({2'b00, q_l[l]});
      sure_nxt[l] = neg_l[l] ? (nz && lt) : gt;
      tie_nxt[l]  = nz && eq;
    end
  end

  // base placement, tie goes up for nonnegative floor
  always_comb begin
    up = 1'b0;
    for (int l = 0; l < 2; l++) begin
      total[l]     = (TW'(base1_r[l]) <<< FRAC_BITS) + TW'(fl1_r[l]);
      up           = sure1_r[l] || (tie1_r[l] && !total[l][TW-1]);
      res[l]       = total[l] + TW'(up);
      cross_nxt[l] = hit1_r ? OW'(res[l]) : '0;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) begin
        v_r[0] <= in_valid;
      end
      if (rdy[1]) begin
        v_r[1] <= v_r[0];
      end
    end
  end

  // stage 1
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      hit1_r     <= in_sb.hit;
      base1_r[0] <= in_sb.base_x;
      base1_r[1] <= in_sb.base_y;
      for (int l = 0; l < 2; l++) begin
        fl1_r[l]   <= fl_nxt[l];
        sure1_r[l] <= sure_nxt[l];
        tie1_r[l]  <= tie_nxt[l];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      hit_r      <= hit1_r;
      cross_r[0] <= cross_nxt[0];
      cross_r[1] <= cross_nxt[1];
    end
  end

  assign out_hit     = hit_r;
  assign out_cross_x = cross_r[0];
  assign out_cross_y = cross_r[1];

  // a miss reports the origin
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[1] && !hit_r |-> (cross_r[0] == '0) && (cross_r[1] == '0))
    else $error("miss with nonzero point");

endmodule

// ===== src/segment_intersection_top.sv =====
// top level of the segment intersection pipeline
//
//  port group  dir  tdata / tuser (lowest bit first)
//  in_         in   tdata: ax0, ay0, ax1, ay1, bx0, by0, bx1, by1 (16 bits signed each)
//  out_        out  tdata: cross_x, cross_y (24 bits signed, FRAC_BITS fraction bits)
//                   tuser: hit
//
//  one request per cycle sustained while the output is not stalled
//  the divider yields one quotient bit per stage over 16 + FRAC_BITS stages
//  five front stages (differences, products, cross sums, range test, numerator products)
//  and two rounding stages, the last of which is the output register
//  each stage holds its request when the next is full and stalled; empty stages still fill
//  rst_n is synchronous, active low, and clears only the valid bits
module segment_intersection_top #(
  parameter int FRAC_BITS = si_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [si_pkg::IN_DATA_W-1:0]    in_tdata,   // ax0, ay0, ax1, ay1, bx0, by0, bx1, by1
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [si_pkg::OUT_DATA_W-1:0]   out_tdata,  // cross_x, cross_y
  output logic [0:0]                      out_tuser   // hit
);

  localparam int QW = si_pkg::DIFF_W - 1 + FRAC_BITS;

  logic          fr_valid, fr_ready;
  si_pkg::frt_t  fr_pl;
  logic          dv_valid, dv_ready;
  si_pkg::sb_t   dv_sb;
  logic [QW-1:0] dv_q_x, dv_q_y;
  logic [si_pkg::CROSS_W-1:0] dv_rem_x, dv_rem_y;
  logic          dv_neg_x, dv_neg_y;
  logic          hit;
  logic [si_pkg::OUT_W-1:0] cross_x, cross_y;

  // cross products and range test
  si_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_data   (in_tdata),
    .out_valid (fr_valid),
    .out_ready (fr_ready),
    .out_pl    (fr_pl)
  );

  // numerator times 2^F over denominator
  si_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fr_valid),
    .in_ready  (fr_ready),
    .in_pl     (fr_pl),
    .out_valid (dv_valid),
    .out_ready (dv_ready),
    .out_sb    (dv_sb),
    .out_q_x   (dv_q_x),
    .out_q_y   (dv_q_y),
    .out_rem_x (dv_rem_x),
    .out_rem_y (dv_rem_y),
    .out_neg_x (dv_neg_x),
    .out_neg_y (dv_neg_y)
  );

  // rounding and output register
  si_round #(.FRAC_BITS(FRAC_BITS)) u_round (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (dv_valid),
    .in_ready    (dv_ready),
    .in_sb       (dv_sb),
    .in_q_x      (dv_q_x),
    .in_q_y      (dv_q_y),
    .in_rem_x    (dv_rem_x),
    .in_rem_y    (dv_rem_y),
    .in_neg_x    (dv_neg_x),
    .in_neg_y    (dv_neg_y),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_hit     (hit),
    .out_cross_x (cross_x),
    .out_cross_y (cross_y)
  );

  assign out_tdata = {cross_y, cross_x};
  assign out_tuser = hit;

  // input backs up only when every stage is full behind a stalled output
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled while pipeline can move");

endmodule

// ===== tb/sv/tb_top.sv =====
// testbench of the segment intersection pipeline: directed and random segment pairs, checked in order
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC        = si_pkg::FRAC_BITS_DEF;
  localparam int N_RANDOM    = 1530;
  localparam int GAP_MAX     = 14;
  localparam int BURST_FROM  = 300;   // sender offers back to back over this span of pairs
  localparam int BURST_TO    = 520;
  localparam int HOLD_AT     = 310;   // receiver holds off once this many results have come
  localparam int HOLD_CYCLES = 500;
  localparam int DRAIN_AT    = 800;
  localparam int TAIL_CYCLES = 64;

  // one segment pair, ax0 in the lowest bits as on in_tdata
  typedef struct packed {
    logic signed [si_pkg::COORD_W-1:0] by1, bx1, by0, bx0, ay1, ax1, ay0, ax0;
  } seg_pair_t;

  // one crossing result, as carried by out_tuser and out_tdata
  typedef struct packed {
    logic                             hit;
    logic signed [si_pkg::OUT_W-1:0] cross_x;
    logic signed [si_pkg::OUT_W-1:0] cross_y;
  } crossing_t;

  typedef struct {
    seg_pair_t pair;
    bit        known;
    crossing_t want;
  } dir_row_t;

  logic                         clk = 1'b0;
  logic                         rst_n;
  logic                         in_tvalid;
  logic                         in_tready;
  logic [si_pkg::IN_DATA_W-1:0] in_tdata;   // ax0, ay0, ax1, ay1, bx0, by0, bx1, by1
  logic                         out_tvalid;
  logic                         out_tready;
  logic [si_pkg::OUT_DATA_W-1:0] out_tdata; // cross_x, cross_y
  logic [0:0]                   out_tuser;  // hit

  crossing_t crossing_q[$];
  dir_row_t  dir_rows[$];
  int        pairs_sent     = 0;
  int        results_seen   = 0;
  int        mismatch_count = 0;

  segment_intersection_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic seg_pair_t mk_pair(int ax0, int ay0, int ax1, int ay1,
                                        int bx0, int by0, int bx1, int by1);
    seg_pair_t p;
    p.ax0 = 16'(ax0);
    p.ay0 = 16'(ay0);
    p.ax1 = 16'(ax1);
    p.ay1 = 16'(ay1);
    p.bx0 = 16'(bx0);
    p.by0 = 16'(by0);
    p.bx1 = 16'(bx1);
    p.by1 = 16'(by1);
    return p;
  endfunction

  function automatic void add_row(seg_pair_t p, bit known, bit hit, int cx, int cy);
    dir_row_t row;
    row.pair         = p;
    row.known        = known;
    row.want.hit     = hit;
    row.want.cross_x = 24'(cx);
    row.want.cross_y = 24'(cy);
    dir_rows = {dir_rows, row};
  endfunction

  function automatic int span(int lo, int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  // 0 <= num/den <= 1, never for a zero denominator
  function automatic bit ratio_in_unit(longint num, longint den);
    if (den > 0) return num >= 0 && num <= den;
    if (den < 0) return num <= 0 && num >= den;
    return 1'b0;
  endfunction

  // base + num/den in fixed point, nearest with ties away from zero, den > 0
  function automatic longint round_point(longint base, longint num, longint den);
    longint unsigned d, a, q, r, rs, rem, twice;
    longint          fl, total;
    d  = den;
    a  = (num < 0) ? -num : num;
    q  = a / d;
    r  = a % d;
    rs = r << FRAC;
    fl = longint'((q << FRAC) + rs / d);
    rem = rs % d;
    // floor of a negative quotient, remainder kept positive
    if (num < 0) begin
      fl = -fl;
      if (rem != 0) begin
        fl  = fl - 1;
        rem = d - rem;
      end
    end
    total = base * (longint'(1) << FRAC) + fl;
    if (rem != 0) begin
      twice = rem * 2;
      if (twice > d || (twice == d && total >= 0)) total = total + 1;
    end
    return total;
  endfunction

  // expected crossing of one segment pair
  function automatic crossing_t predict_crossing(seg_pair_t p);
    longint    d1x, d1y, d2x, d2y, wx, wy, den, sn, tn, px, py;
    crossing_t r;
    r   = '0;
    d1x = longint'(p.ax1) - longint'(p.ax0);
    d1y = longint'(p.ay1) - longint'(p.ay0);
    d2x = longint'(p.bx1) - longint'(p.bx0);
    d2y = longint'(p.by1) - longint'(p.by0);
    wx  = longint'(p.ax0) - longint'(p.bx0);
    wy  = longint'(p.ay0) - longint'(p.by0);
    den = d1x * d2y - d2x * d1y;
    sn  = d1x * wy - d1y * wx;
    tn  = d2x * wy - d2y * wx;
    if (!ratio_in_unit(sn, den) || !ratio_in_unit(tn, den)) return r;
    if (den < 0) begin
      den = -den;
      tn  = -tn;
    end
    px = round_point(longint'(p.ax0), tn * d1x, den);
    py = round_point(longint'(p.ay0), tn * d1y, den);
    r.hit     = 1'b1;
    r.cross_x = px[si_pkg::OUT_W-1:0];
    r.cross_y = py[si_pkg::OUT_W-1:0];
    return r;
  endfunction

  // random pair: raw bits, pairs built to cross, tiny coordinates, shared ends and parallels
  function automatic seg_pair_t random_pair();
    int kind, cx, cy, ux, uy, vx, vy, ax0, ay0, ax1, ay1, bx1, by1;
    kind = $urandom_range(99);
    if (kind < 35)
      return mk_pair($urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom);
    if (kind < 75) begin
      cx = span(-16000, 16000);
      cy = span(-16000, 16000);
      ux = span(-16000, 16000);
      uy = span(-16000, 16000);
      vx = span(-16000, 16000);
      vy = span(-16000, 16000);
      return mk_pair(cx + ux, cy + uy, cx - ux + span(-2, 2), cy - uy + span(-2, 2),
                     cx + vx, cy + vy, cx - vx + span(-2, 2), cy - vy + span(-2, 2));
    end
    if (kind < 90)
      return mk_pair(span(-6, 6), span(-6, 6), span(-6, 6), span(-6, 6),
                     span(-6, 6), span(-6, 6), span(-6, 6), span(-6, 6));
    ax0 = span(-1000, 1000);
    ay0 = span(-1000, 1000);
    ax1 = span(-1000, 1000);
    ay1 = span(-1000, 1000);
    bx1 = span(-1000, 1000);
    by1 = span(-1000, 1000);
    // second segment starts on the end of the first
    if (kind < 95) return mk_pair(ax0, ay0, ax1, ay1, ax1, ay1, bx1, by1);
    // second segment parallel to the first
    return mk_pair(ax0, ay0, ax1, ay1, bx1, by1, bx1 + ax1 - ax0, by1 + ay1 - ay0);
  endfunction

  // offer one pair after a random gap, record its expected crossing on acceptance
  task automatic send_pair(seg_pair_t p, bit known, crossing_t want);
    int        gap, gap_hi;
    crossing_t expect_c;
    if (pairs_sent >= BURST_FROM && pairs_sent < BURST_TO) begin
      gap_hi = 0;
    end else begin
      case ((pairs_sent / 50) % 3)
        0:       gap_hi = GAP_MAX;
        1:       gap_hi = 0;
        default: gap_hi = 3;
      endcase
    end
    gap = $urandom_range(gap_hi);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= p;
    do @(posedge clk); while (!in_tready);
    expect_c   = known ? want : predict_crossing(p);
    crossing_q = {crossing_q, expect_c};
    pairs_sent++;
  endtask

  // stop offering until every expected crossing has come back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (crossing_q.size() != 0);
  endtask

  // reset, directed table, random pairs, verdict
  initial begin : pair_side
    crossing_t no_crossing;
    no_crossing = '0;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;

    // degenerate and parallel pairs miss
    add_row(mk_pair(0, 0, 0, 0, 0, 0, 0, 0), 1, 0, 0, 0);
    add_row(mk_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767), 1, 0, 0, 0);
    add_row(mk_pair(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768),
            1, 0, 0, 0);
    add_row(mk_pair(0, 0, 10, 0, 0, 5, 10, 5), 1, 0, 0, 0);
    add_row(mk_pair(0, 0, 10, 0, 5, 0, 15, 0), 1, 0, 0, 0);
    add_row(mk_pair(3, 3, 3, 3, 0, 0, 6, 6), 1, 0, 0, 0);
    // plain crossing at (5,5)
    add_row(mk_pair(0, 0, 10, 10, 0, 10, 10, 0), 1, 1, 1280, 1280);
    // touching at either end of the first segment, then just past the ends
    add_row(mk_pair(0, 0, 10, 0, 0, -5, 0, 5), 1, 1, 0, 0);
    add_row(mk_pair(0, 0, 10, 0, 10, -5, 10, 5), 1, 1, 2560, 0);
    add_row(mk_pair(0, 0, 10, 0, 11, -5, 11, 5), 1, 0, 0, 0);
    add_row(mk_pair(0, 0, 10, 0, 5, 1, 5, 11), 1, 0, 0, 0);
    // points at the extremes of the output range
    add_row(mk_pair(32767, 32767, 0, 0, 32767, 32767, 32767, 0), 1, 1, 8388352, 8388352);
    add_row(mk_pair(-32768, -32768, 0, 0, -32768, -32768, -32768, 0),
            1, 1, -8388608, -8388608);
    // full-range diagonals and long edges
    add_row(mk_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768),
            0, 0, 0, 0);
    add_row(mk_pair(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767),
            0, 0, 0, 0);
    add_row(mk_pair(-32768, 0, 32767, 0, 32767, -32768, 32767, 32767), 0, 0, 0, 0);
    // rounding ties on both signs, and thirds
    add_row(mk_pair(0, 0, 1, -512, -2, -1, 2, -1), 0, 0, 0, 0);
    add_row(mk_pair(0, 0, -1, -512, -2, -1, 2, -1), 0, 0, 0, 0);
    add_row(mk_pair(0, 0, 1, 3, -5, 1, 5, 1), 0, 0, 0, 0);
    add_row(mk_pair(0, 0, -1, -3, -5, -1, 5, -1), 0, 0, 0, 0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[k]) send_pair(dir_rows[k].pair, dir_rows[k].known, dir_rows[k].want);
    drain_results();

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == DRAIN_AT) drain_results();
      send_pair(random_pair(), 1'b0, no_crossing);
    end
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  // accept results after random stalls, one long hold-off, compare in order
  initial begin : result_side
    int        stall, hi;
    bit        held;
    crossing_t got, want;
    held       = 1'b0;
    out_tready = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      case ((results_seen / 64) % 3)
        0:       hi = GAP_MAX;
        1:       hi = 0;
        default: hi = 2;
      endcase
      stall = $urandom_range(hi);
      if (results_seen == HOLD_AT && !held) begin
        held  = 1'b1;
        stall = HOLD_CYCLES;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      got.hit     = out_tuser[0];
      got.cross_x = out_tdata[si_pkg::OUT_W-1:0];
      got.cross_y = out_tdata[2*si_pkg::OUT_W-1:si_pkg::OUT_W];
      results_seen++;
      if (crossing_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("result %0d arrived with none expected: hit=%0d x=%0d y=%0d",
                   results_seen, got.hit, got.cross_x, got.cross_y);
      end else begin
        want = crossing_q.pop_front();
        if (got.hit !== want.hit || got.cross_x !== want.cross_x ||
            got.cross_y !== want.cross_y) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result %0d: expected hit=%0d x=%0d y=%0d, got hit=%0d x=%0d y=%0d",
                     results_seen, want.hit, want.cross_x, want.cross_y,
                     got.hit, got.cross_x, got.cross_y);
        end
      end
    end
  end

  // run limit
  initial begin : watchdog
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
